>>> rtl/core/tle_pkg.sv
// Shared constants for the terminal line editor.
package tle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int PTR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_RAW_MODE = 1'd0;
  localparam logic [ADDR_W-3:0] REG_ECHO_ENABLE = 1'd1;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CTRL_TOP = 8'd27;

  localparam logic [1:0] ECHO_CHAR = 2'd0;
  localparam logic [1:0] ECHO_ERASE = 2'd1;
  localparam logic [1:0] ECHO_LF = 2'd2;
  localparam logic [1:0] ECHO_CRLF = 2'd3;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_RAW = 2'd1;
  localparam logic [1:0] TAIL_FLUSH = 2'd2;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LINE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(LINE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

>>> rtl/core/tle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tty_line_editor_core.sv
// Terminal line editor: raw pass-through or canonical line editing with echo.
// A byte's first result passes the state register, then the output register;
// a CR with echo off and a nonempty line first reads the line store.
// A new byte is taken only in idle, after all results of the last one are loaded;
// a CR gives CR, LF echo if echo is on, then an empty mark, or a read setup and
// one line byte per cycle from the single read port unless the output stalls.
// Reset: read_ptr, write_ptr 0; raw_mode 0, echo_enable 1; store not cleared.
module tty_line_editor_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tle_pkg::ADDR_W-1:0]  paddr,
  input  logic [tle_pkg::DATA_W-1:0]  pwdata,
  output logic [tle_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [7:0]                  out_byte,
  output logic                        line_end,
  output logic                        last
);
  import tle_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ECHO = 3'd1;
  localparam logic [2:0] S_RAW = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FOUT = 3'd4;

  logic             raw_mode;
  logic             echo_enable;
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [7:0]       cur_byte;
  logic [1:0]       echo_sel;
  logic [1:0]       echo_cnt;
  logic [1:0]       step;
  logic [1:0]       tail;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] rd_ptr;

  logic             in_xfer;
  logic             slot_free;
  logic             out_load;
  logic             cfg_wr;
  logic             is_print;
  logic             is_erase;
  logic [1:0]       echo_sel_next;
  logic [1:0]       echo_cnt_next;
  logic [1:0]       tail_next;
  logic             mem_we;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rd_inc;
  logic [7:0]       echo_byte;
  logic             echo_last;
  logic             flush_end;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[ADDR_W-1:2] == REG_RAW_MODE) ? DATA_W'(raw_mode) :
                  DATA_W'(echo_enable);

  assign in_ready = (state == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign is_print = (rx_byte != CH_DEL) && (rx_byte > CTRL_TOP);
  assign is_erase = (rx_byte == CH_DEL) || (rx_byte == CH_BS);
  assign wp_inc = ptr_inc(write_ptr);
  assign rd_inc = ptr_inc(rd_ptr);
  assign flush_end = (rd_inc == write_ptr);

  always_comb begin
    echo_sel_next = ECHO_CHAR;
    echo_cnt_next = 2'd0;
    tail_next = TAIL_NONE;
    if (raw_mode) begin
      echo_cnt_next = {1'b0, echo_enable};
      tail_next = TAIL_RAW;
    end else if (is_print) begin
      echo_cnt_next = {1'b0, echo_enable};
    end else if (is_erase) begin
      echo_sel_next = ECHO_ERASE;
      echo_cnt_next = echo_enable ? 2'd3 : 2'd0;
    end else if (rx_byte == CH_LF) begin
      echo_sel_next = ECHO_LF;
      echo_cnt_next = {1'b0, echo_enable};
    end else if (rx_byte == CH_CR) begin
      echo_sel_next = ECHO_CRLF;
      echo_cnt_next = echo_enable ? 2'd2 : 2'd0;
      tail_next = TAIL_FLUSH;
    end
  end

  always_comb begin
    case (echo_sel)
      ECHO_CHAR:  echo_byte = cur_byte;
      ECHO_ERASE: echo_byte = (step == 2'd1) ? CH_SP : CH_BS;
      ECHO_LF:    echo_byte = CH_LF;
      ECHO_CRLF:  echo_byte = (step == 2'd0) ? CH_CR : CH_LF;
      default:    echo_byte = cur_byte;
    endcase
  end

  assign echo_last = (step == echo_cnt - 2'd1);
  assign mem_we = in_xfer && !raw_mode && is_print;

  always_comb begin
    state_next = state;
    mem_re = 1'b0;
    mem_raddr = read_ptr;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (echo_cnt_next != 2'd0) begin
            state_next = S_ECHO;
          end else if (tail_next == TAIL_RAW) begin
            state_next = S_RAW;
          end else if (tail_next == TAIL_FLUSH) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_ECHO: begin
        out_load = slot_free;
        if (slot_free && echo_last) begin
          case (tail)
            TAIL_RAW:   state_next = S_RAW;
            TAIL_FLUSH: state_next = S_FLUSH;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_RAW: begin
        out_load = slot_free;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (read_ptr != write_ptr) begin
          mem_re = 1'b1;
          state_next = S_FOUT;
        end else if (slot_free) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FOUT: begin
        out_load = slot_free;
        if (slot_free) begin
          if (flush_end) begin
            state_next = S_IDLE;
          end else begin
            mem_re = 1'b1;
            mem_raddr = rd_inc;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(write_ptr),
    .wdata(rx_byte),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
      echo_enable <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_RAW_MODE:    raw_mode <= pwdata[0];
        REG_ECHO_ENABLE: echo_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      read_ptr <= '0;
      write_ptr <= '0;
      out_valid <= 1'b0;
      step <= 2'd0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_xfer) begin
        step <= 2'd0;
        if (!raw_mode && is_print) begin
          write_ptr <= wp_inc;
          if (wp_inc == read_ptr) begin
            read_ptr <= ptr_inc(read_ptr);
          end
        end else if (!raw_mode && is_erase && (write_ptr != read_ptr)) begin
          write_ptr <= ptr_dec(write_ptr);
        end
      end
      case (state)
        S_ECHO: begin
          if (slot_free) begin
            step <= step + 2'd1;
          end
        end
        S_FOUT: begin
          if (slot_free && flush_end) begin
            read_ptr <= write_ptr;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_byte <= rx_byte;
      echo_sel <= echo_sel_next;
      echo_cnt <= echo_cnt_next;
      tail <= tail_next;
    end
    case (state)
      S_ECHO: begin
        if (slot_free) begin
          kind <= KIND_ECHO;
          out_byte <= echo_byte;
          line_end <= 1'b0;
          last <= echo_last && (tail == TAIL_NONE);
        end
      end
      S_RAW: begin
        if (slot_free) begin
          kind <= KIND_DATA;
          out_byte <= cur_byte;
          line_end <= 1'b1;
          last <= 1'b1;
        end
      end
      S_FLUSH: begin
        if (read_ptr != write_ptr) begin
          rd_ptr <= read_ptr;
        end else if (slot_free) begin
          kind <= KIND_EMPTY;
          out_byte <= 8'd0;
          line_end <= 1'b1;
          last <= 1'b1;
        end
      end
      S_FOUT: begin
        if (slot_free) begin
          kind <= KIND_DATA;
          out_byte <= mem_rdata;
          line_end <= flush_end;
          last <= flush_end;
          rd_ptr <= rd_inc;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/sv/tb_tty_line_editor_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for tty_line_editor_core: directed byte table, then random lines and raw bytes.
module tb_tty_line_editor_core;
  import tle_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 22;
  localparam int NUM_PHASES = 6;
  localparam int PLAN_LEN = 24;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       line_end;
    logic       last;
  } term_out_t;

  typedef enum logic {ROW_CHAR, ROW_MODE} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic       raw;
    logic       echo;
    logic [7:0] ch;
    logic [1:0] n_typed;
    term_out_t  t0;
    term_out_t  t1;
    term_out_t  t2;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        kind;
  logic [7:0]        out_byte;
  logic              line_end;
  logic              last;

  logic [7:0] line_mem [LINE_DEPTH];
  int         oldest;
  int         next_free;
  logic       mode_raw;
  logic       mode_echo;
  term_out_t  step_out [$];
  term_out_t  due_out [$];
  term_out_t  want_out;
  plan_row_t  plan [PLAN_LEN];
  int         errors;
  int         sent;
  int         in_idle_max;
  int         out_idle_max;
  logic       hold_req;
  int         stall_cycles;

  tty_line_editor_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .line_end  (line_end),
    .last      (last)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic term_out_t ech(input logic [7:0] c, input logic lst);
    return term_out_t'{KIND_ECHO, c, 1'b0, lst};
  endfunction

  function automatic term_out_t dat(input logic [7:0] c);
    return term_out_t'{KIND_DATA, c, 1'b1, 1'b1};
  endfunction

  function automatic plan_row_t char_row(input logic [7:0] c);
    return plan_row_t'{ROW_CHAR, 1'b0, 1'b0, c, 2'd0, '0, '0, '0};
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] c, input logic [1:0] n,
                                          input term_out_t a, input term_out_t b,
                                          input term_out_t d);
    return plan_row_t'{ROW_CHAR, 1'b0, 1'b0, c, n, a, b, d};
  endfunction

  function automatic plan_row_t mode_row(input logic raw, input logic echo);
    return plan_row_t'{ROW_MODE, raw, echo, 8'd0, 2'd0, '0, '0, '0};
  endfunction

  function automatic void queue_char(input logic [1:0] k, input logic [7:0] c,
                                     input logic le);
    step_out.push_back(term_out_t'{k, c, le, 1'b0});
  endfunction

  function automatic void edit_char(input logic [7:0] c);
    int p;
    int nx;
    step_out.delete();
    if (mode_raw) begin
      if (mode_echo) queue_char(KIND_ECHO, c, 1'b0);
      queue_char(KIND_DATA, c, 1'b1);
    end else if (c != CH_DEL && c > CTRL_TOP) begin
      line_mem[next_free] = c;
      next_free = (next_free + 1) % LINE_DEPTH;
      if (next_free == oldest) oldest = (oldest + 1) % LINE_DEPTH;
      if (mode_echo) queue_char(KIND_ECHO, c, 1'b0);
    end else if (c == CH_DEL || c == CH_BS) begin
      if (next_free != oldest) next_free = (next_free + LINE_DEPTH - 1) % LINE_DEPTH;
      if (mode_echo) begin
        queue_char(KIND_ECHO, CH_BS, 1'b0);
        queue_char(KIND_ECHO, CH_SP, 1'b0);
        queue_char(KIND_ECHO, CH_BS, 1'b0);
      end
    end else if (c == CH_LF) begin
      if (mode_echo) queue_char(KIND_ECHO, CH_LF, 1'b0);
    end else if (c == CH_CR) begin
      if (mode_echo) begin
        queue_char(KIND_ECHO, CH_CR, 1'b0);
        queue_char(KIND_ECHO, CH_LF, 1'b0);
      end
      if (oldest == next_free) begin
        queue_char(KIND_EMPTY, 8'd0, 1'b1);
      end else begin
        p = oldest;
        while (p != next_free) begin
          nx = (p + 1) % LINE_DEPTH;
          queue_char(KIND_DATA, line_mem[p], nx == next_free);
          p = nx;
        end
        oldest = next_free;
      end
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_canon();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 8'($urandom_range(28, 255));
    if (r < 15) return CH_BS;
    if (r == 15) return CH_DEL;
    if (r == 16) return CH_LF;
    if (r == 17) return 8'($urandom_range(0, 27));
    if (r == 18) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(28, 126));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d (after %0d transfers in)",
             what, got, want, sent);
    errors++;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [ADDR_W-1:0] a, output logic [DATA_W-1:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    d = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic raw, input logic echo);
    logic [DATA_W-1:0] rd;
    wait_drained();
    apb_write({REG_RAW_MODE, 2'b00}, (DATA_W'($urandom) & ~DATA_W'(1)) | DATA_W'(raw));
    apb_write({REG_ECHO_ENABLE, 2'b00}, (DATA_W'($urandom) & ~DATA_W'(1)) | DATA_W'(echo));
    mode_raw = raw;
    mode_echo = echo;
    apb_read({REG_RAW_MODE, 2'b00}, rd);
    if (rd !== DATA_W'(raw)) report_mismatch("raw_mode readback", rd, raw);
    apb_read({REG_ECHO_ENABLE, 2'b00}, rd);
    if (rd !== DATA_W'(echo)) report_mismatch("echo_enable readback", rd, echo);
  endtask

  task automatic send_byte(input plan_row_t r);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= r.ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edit_char(r.ch);
    if (r.n_typed == 2'd0) begin
      foreach (step_out[i]) due_out.push_back(step_out[i]);
    end else begin
      due_out.push_back(r.t0);
      if (r.n_typed > 2'd1) due_out.push_back(r.t1);
      if (r.n_typed > 2'd2) due_out.push_back(r.t2);
    end
    sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_out.size() == 0) begin
        report_mismatch("unexpected result, out_byte", out_byte, 0);
      end else begin
        want_out = due_out.pop_front();
        if (kind !== want_out.kind) report_mismatch("kind", kind, want_out.kind);
        if (out_byte !== want_out.ch) report_mismatch("out_byte", out_byte, want_out.ch);
        if (line_end !== want_out.line_end)
          report_mismatch("line_end", line_end, want_out.line_end);
        if (last !== want_out.last) report_mismatch("last", last, want_out.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_tty_line_editor_core failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = $urandom_range(0, out_idle_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int   budget;
    int   len;
    logic raw_sel;
    logic echo_sel;
    logic first_line;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    hold_req = 1'b0;
    errors = 0;
    sent = 0;
    in_idle_max = 3;
    out_idle_max = 3;
    mode_raw = 1'b0;
    mode_echo = 1'b1;
    oldest = 0;
    next_free = 0;
    plan = '{
      typed_row(CH_CR, 2'd3, ech(CH_CR, 1'b0), ech(CH_LF, 1'b0),
                term_out_t'{KIND_EMPTY, 8'd0, 1'b1, 1'b1}),
      typed_row(CH_BS, 2'd3, ech(CH_BS, 1'b0), ech(CH_SP, 1'b0), ech(CH_BS, 1'b1)),
      typed_row(8'd28, 2'd1, ech(8'd28, 1'b1), '0, '0),
      typed_row(8'd255, 2'd1, ech(8'd255, 1'b1), '0, '0),
      typed_row(8'd126, 2'd1, ech(8'd126, 1'b1), '0, '0),
      typed_row(8'd128, 2'd1, ech(8'd128, 1'b1), '0, '0),
      char_row(CTRL_TOP),
      char_row(8'd0),
      typed_row(CH_DEL, 2'd3, ech(CH_BS, 1'b0), ech(CH_SP, 1'b0), ech(CH_BS, 1'b1)),
      typed_row(CH_LF, 2'd1, ech(CH_LF, 1'b1), '0, '0),
      char_row(CH_CR),
      mode_row(1'b0, 1'b0),
      char_row(8'd120),
      char_row(8'd121),
      char_row(CH_BS),
      char_row(CH_LF),
      char_row(CH_CR),
      mode_row(1'b1, 1'b1),
      typed_row(8'd0, 2'd2, ech(8'd0, 1'b0), dat(8'd0), '0),
      typed_row(8'd255, 2'd2, ech(8'd255, 1'b0), dat(8'd255), '0),
      typed_row(CH_CR, 2'd2, ech(CH_CR, 1'b0), dat(CH_CR), '0),
      mode_row(1'b1, 1'b0),
      typed_row(CH_DEL, 2'd1, dat(CH_DEL), '0, '0),
      typed_row(CH_BS, 2'd1, dat(CH_BS), '0, '0)
    };
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      if (plan[i].op == ROW_MODE) set_mode(plan[i].raw, plan[i].echo);
      else send_byte(plan[i]);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      raw_sel = (ph == 2 || ph == 3) ? 1'b1 : (ph == 5) ? 1'($urandom_range(0, 1)) : 1'b0;
      echo_sel = (ph == 1 || ph == 3) ? 1'b0 : (ph == 5) ? 1'($urandom_range(0, 1)) : 1'b1;
      set_mode(raw_sel, echo_sel);
      in_idle_max = (ph % 2 == 1) ? 6 : 0;
      out_idle_max = (ph % 3 == 1) ? 0 : 6;
      if (ph == 0) hold_req = 1'b1;
      budget = sent + PHASE_ITEMS;
      first_line = 1'b1;
      while (sent < budget) begin
        if (raw_sel) begin
          send_byte(char_row(8'($urandom_range(0, 255))));
        end else begin
          if ((first_line && ph == 0) || $urandom_range(0, 5) == 0)
            len = $urandom_range(LINE_DEPTH + 1, LINE_DEPTH + 8);
          else
            len = $urandom_range(0, 10);
          repeat (len) send_byte(char_row(pick_canon()));
          if (first_line && ph == 4) wait_drained();
          send_byte(char_row(CH_CR));
          first_line = 1'b0;
        end
      end
    end
    wait_drained();
    if (errors == 0) begin
      $display("tb_tty_line_editor_core passed");
    end else begin
      $display("tb_tty_line_editor_core failed");
    end
    $finish;
  end

endmodule
